/* design/image_header_dimension_sniffer_top_assert.svh */
// ----------------------------------------------------------------------------
// image header dimension sniffer assertion macros
// checks are clocked on aclk and held off while aresetn is low
// ----------------------------------------------------------------------------
`ifndef IMAGE_HEADER_DIMENSION_SNIFFER_TOP_ASSERT_SVH
`define IMAGE_HEADER_DIMENSION_SNIFFER_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge out of reset
`define IHDS_ASSERT(name, prop) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("ihds assertion failed");
// expression must never be true out of reset
`define IHDS_NEVER(name, expr) `IHDS_ASSERT(name, !(expr))
`else
`define IHDS_ASSERT(name, prop)
`define IHDS_NEVER(name, expr)
`endif

`endif

/* design/ihds_pkg.sv */
// ----------------------------------------------------------------------------
// ihds_pkg
// shared types, codes and helpers of the image header dimension sniffer
// ----------------------------------------------------------------------------
package ihds_pkg;

    // result formats
    localparam logic [2:0] FMT_PNG  = 3'd0;
    localparam logic [2:0] FMT_GIF  = 3'd1;
    localparam logic [2:0] FMT_BMP  = 3'd2;
    localparam logic [2:0] FMT_VP8  = 3'd3;
    localparam logic [2:0] FMT_VP8L = 3'd4;
    localparam logic [2:0] FMT_VP8X = 3'd5;
    localparam logic [2:0] FMT_JPEG = 3'd6;

    // candidate bits of the signature match
    localparam int SM_PNG  = 0;
    localparam int SM_GIF  = 1;
    localparam int SM_BMP  = 2;
    localparam int SM_VP8  = 3;
    localparam int SM_VP8L = 4;
    localparam int SM_VP8X = 5;
    localparam int SM_JPEG = 6;
    localparam logic [6:0] SM_ALL = 7'h7F;

    localparam logic [7:0]  MARK_APP1   = 8'hE1;
    localparam logic [15:0] TAG_ORIENT  = 16'h0112;
    localparam logic [15:0] TIFF_MAGIC  = 16'd42;
    localparam logic [31:0] MASK_14     = 32'h0000_3FFF;
    localparam logic [31:0] MASK_24     = 32'h00FF_FFFF;

    // parse phase
    typedef enum logic [7:0] {
        PH_SIG  = 8'b0000_0001,
        PH_SEEK = 8'b0000_0010,
        PH_MARK = 8'b0000_0100,
        PH_LEN1 = 8'b0000_1000,
        PH_LEN2 = 8'b0001_0000,
        PH_SKIP = 8'b0010_0000,
        PH_SOF  = 8'b0100_0000,
        PH_DONE = 8'b1000_0000
    } ihds_phase_t;

    // exif sub-phase
    typedef enum logic [2:0] {
        EX_IDLE = 3'b001,
        EX_HEAD = 3'b010,
        EX_IFD  = 3'b100
    } ihds_exif_t;

    // one result transaction
    typedef struct packed {
        logic        swapped;
        logic [31:0] height;
        logic [31:0] width;
        logic [2:0]  format;
        logic        found;
    } ihds_result_t;

    // byte placed into one of four lanes of a word
    function automatic logic [31:0] lane_place(input logic [7:0] b, input logic [1:0] lane);
        lane_place = {24'd0, b} << {lane, 3'b000};
    endfunction

    // endian aware 16 bit build, first byte clears the value
    function automatic logic [15:0] put16(input logic le, input logic idx,
                                          input logic [15:0] cur, input logic [7:0] b);
        if (!idx) begin
            put16 = le ? {8'd0, b} : {b, 8'd0};
        end else begin
            put16 = cur | (le ? {b, 8'd0} : {8'd0, b});
        end
    endfunction

endpackage

/* design/ihds_parse.sv */
// ----------------------------------------------------------------------------
// ihds_parse
// front part: takes one file byte per cycle while in_ready is high,
// tracks the header parse and produces at most one result for each byte
// ----------------------------------------------------------------------------
`include "image_header_dimension_sniffer_top_assert.svh"

module ihds_parse #(
    parameter int POSITION_BITS = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    input  logic                  in_ready,
    input  logic [7:0]            in_byte,
    input  logic                  in_last,
    output logic                  res_valid,
    output ihds_pkg::ihds_result_t res
);

    localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

    logic                     acc;
    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    ihds_pkg::ihds_phase_t    phase_reg, phase_next;
    ihds_pkg::ihds_exif_t     exph_reg, exph_next;
    logic [6:0]               match_reg, match_next;
    logic [31:0]              acc0_reg, acc0_next, acc1_reg, acc1_next;
    logic [16:0]              skip_reg, skip_next;
    logic [15:0]              seglen_reg, seglen_next;
    logic [7:0]               marker_reg, marker_next;
    logic                     le_reg, le_next;
    logic [7:0]               hb_reg [7];
    logic [31:0]              ifdpos_reg, ifdpos_next;
    logic [15:0]              entries_reg, entries_next;
    logic [15:0]              tag_reg, tag_next;
    logic [3:0]               orient_reg, orient_next;
    logic                     done_reg, done_next;
    logic [15:0]              q_reg, q_next;
    logic [3:0]               jcnt_reg, jcnt_next;

    logic                     cv;
    ihds_pkg::ihds_result_t   cr;

    // signature helpers
    logic [4:0]  sp;
    logic [7:0]  png_exp, gif_exp, riff_exp;
    logic [6:0]  m;
    logic [31:0] a0, a1, bmp_h;

    // exif helpers
    logic [15:0] rel;
    logic        tiff_ii, tiff_mm, le_new, range_bad;
    logic [15:0] magic;
    logic [31:0] ifd_new;
    logic [2:0]  ifd_lo;
    logic [7:0]  hv0, hv1, hv2, hv3;
    logic [15:0] e0, e1;
    logic        k0, k1, kgt;
    logic [7:0]  exif_exp;

    assign acc = in_valid && in_ready;
    assign sp  = (pos_reg > POSITION_BITS'(31)) ? 5'd31 : pos_reg[4:0];

    // header byte at an index, index seven is the byte on the input
    function automatic logic [7:0] hsel(input logic [2:0] i);
        hsel = (i == 3'd7) ? in_byte : hb_reg[i];
    endfunction

    // expected signature bytes
    always_comb begin
        case (sp[2:0])
            3'd0:    png_exp = 8'h89;
            3'd1:    png_exp = "P";
            3'd2:    png_exp = "N";
            3'd3:    png_exp = "G";
            3'd4:    png_exp = 8'h0D;
            3'd5:    png_exp = 8'h0A;
            3'd6:    png_exp = 8'h1A;
            default: png_exp = 8'h0A;
        endcase
        case (sp[2:0])
            3'd0:    gif_exp = "G";
            3'd1:    gif_exp = "I";
            3'd2:    gif_exp = "F";
            3'd3:    gif_exp = "8";
            3'd4:    gif_exp = "7";
            default: gif_exp = "a";
        endcase
        case (sp[1:0])
            2'd0:    riff_exp = "R";
            2'd1:    riff_exp = "I";
            default: riff_exp = "F";
        endcase
        case (q_reg[2:0])
            3'd0:    exif_exp = "E";
            3'd1:    exif_exp = "x";
            3'd2:    exif_exp = "i";
            3'd3:    exif_exp = "f";
            default: exif_exp = 8'h00;
        endcase
    end

    // tiff header decode at its last byte
    assign rel       = q_reg - 16'd6;
    assign tiff_ii   = (hb_reg[0] == "I") && (hb_reg[1] == "I");
    assign tiff_mm   = (hb_reg[0] == "M") && (hb_reg[1] == "M");
    assign le_new    = tiff_ii ? 1'b1 : (tiff_mm ? 1'b0 : le_reg);
    assign magic     = le_new ? {hb_reg[3], hb_reg[2]} : {hb_reg[2], hb_reg[3]};
    assign ifd_new   = le_new ? {in_byte, hb_reg[6], hb_reg[5], hb_reg[4]}
                              : {hb_reg[4], hb_reg[5], hb_reg[6], in_byte};
    assign range_bad = ({1'b0, ifd_new} + 33'd2) > {17'd0, seglen_reg - 16'd8};
    assign ifd_lo    = ifd_new[2:0];
    assign hv0       = hsel(ifd_lo);
    assign hv1       = hsel(ifd_lo + 3'd1);
    assign hv2       = hsel(ifd_lo + 3'd2);
    assign hv3       = hsel(ifd_lo + 3'd3);
    assign e0        = ihds_pkg::put16(le_new, 1'b0, 16'd0, hv0);
    assign e1        = ihds_pkg::put16(le_new, 1'b1, e0, hv1);

    // position of the byte within the ifd
    assign k0  = {16'd0, rel} == ifdpos_reg;
    assign k1  = {17'd0, rel} == ({1'b0, ifdpos_reg} + 33'd1);
    assign kgt = {17'd0, rel} > ({1'b0, ifdpos_reg} + 33'd1);

    // next state of one accepted byte
    always_comb begin
        pos_next     = (pos_reg == POS_MAX) ? pos_reg : pos_reg + 1'b1;
        phase_next   = phase_reg;
        exph_next    = exph_reg;
        match_next   = match_reg;
        acc0_next    = acc0_reg;
        acc1_next    = acc1_reg;
        skip_next    = skip_reg;
        seglen_next  = seglen_reg;
        marker_next  = marker_reg;
        le_next      = le_reg;
        ifdpos_next  = ifdpos_reg;
        entries_next = entries_reg;
        tag_next     = tag_reg;
        orient_next  = orient_reg;
        done_next    = done_reg;
        q_next       = q_reg;
        jcnt_next    = jcnt_reg;
        cv           = 1'b0;
        cr           = '0;
        m            = match_reg;
        a0           = acc0_reg;
        a1           = acc1_reg;
        bmp_h        = 32'd0;

        case (phase_reg)
            ihds_pkg::PH_SIG: begin
                // drop candidates that disagree with this byte
                if (sp < 5'd8 && in_byte != png_exp) m[ihds_pkg::SM_PNG] = 1'b0;
                if (sp < 5'd6 && !(in_byte == gif_exp || (sp == 5'd4 && in_byte == "9")))
                    m[ihds_pkg::SM_GIF] = 1'b0;
                if (sp == 5'd0 && in_byte != "B") m[ihds_pkg::SM_BMP] = 1'b0;
                if (sp == 5'd1 && in_byte != "M") m[ihds_pkg::SM_BMP] = 1'b0;
                if (sp < 5'd4 && in_byte != riff_exp) m[5:3] = 3'b000;
                if (sp >= 5'd12 && sp < 5'd15) begin
                    if (in_byte != ((sp == 5'd12) ? "V" : ((sp == 5'd13) ? "P" : "8")))
                        m[5:3] = 3'b000;
                end
                if (sp == 5'd15) begin
                    if (in_byte != " ") m[ihds_pkg::SM_VP8]  = 1'b0;
                    if (in_byte != "L") m[ihds_pkg::SM_VP8L] = 1'b0;
                    if (in_byte != "X") m[ihds_pkg::SM_VP8X] = 1'b0;
                end
                if (sp == 5'd0 && in_byte != 8'hFF) m[ihds_pkg::SM_JPEG] = 1'b0;
                if (sp == 5'd1 && in_byte != 8'hD8) m[ihds_pkg::SM_JPEG] = 1'b0;
                match_next = m;
                if (m == 7'd0) begin
                    phase_next = ihds_pkg::PH_DONE;
                end else if (sp == 5'd1 && m[ihds_pkg::SM_JPEG]) begin
                    phase_next = ihds_pkg::PH_SEEK;
                end else begin
                    // gather the size fields
                    if (m[ihds_pkg::SM_PNG] && sp >= 5'd16 && sp < 5'd24) begin
                        if (sp < 5'd20) a0 = a0 | ihds_pkg::lane_place(in_byte, ~sp[1:0]);
                        else            a1 = a1 | ihds_pkg::lane_place(in_byte, ~sp[1:0]);
                    end
                    if (m[ihds_pkg::SM_GIF] && sp >= 5'd6 && sp < 5'd10) begin
                        if (sp < 5'd8) a0 = a0 | ihds_pkg::lane_place(in_byte, {1'b0, sp[0]});
                        else           a1 = a1 | ihds_pkg::lane_place(in_byte, {1'b0, sp[0]});
                    end
                    if (m[ihds_pkg::SM_BMP] && sp >= 5'd18 && sp < 5'd26) begin
                        if (sp < 5'd22) a0 = a0 | ihds_pkg::lane_place(in_byte, sp[1:0] + 2'd2);
                        else            a1 = a1 | ihds_pkg::lane_place(in_byte, sp[1:0] + 2'd2);
                    end
                    if (m[ihds_pkg::SM_VP8] && sp >= 5'd26 && sp < 5'd30) begin
                        if (sp < 5'd28) a0 = a0 | ihds_pkg::lane_place(in_byte, {1'b0, sp[0]});
                        else            a1 = a1 | ihds_pkg::lane_place(in_byte, {1'b0, sp[0]});
                    end
                    if (m[ihds_pkg::SM_VP8L] && sp >= 5'd21 && sp < 5'd25)
                        a0 = a0 | ihds_pkg::lane_place(in_byte, 2'(sp - 5'd21));
                    if (m[ihds_pkg::SM_VP8X] && sp >= 5'd24 && sp < 5'd30) begin
                        if (sp < 5'd27) a0 = a0 | ihds_pkg::lane_place(in_byte, 2'(sp - 5'd24));
                        else            a1 = a1 | ihds_pkg::lane_place(in_byte, 2'(sp - 5'd27));
                    end
                    acc0_next = a0;
                    acc1_next = a1;
                    // bmp height is the absolute value, most negative saturates
                    if (a1 == 32'h8000_0000)  bmp_h = 32'h7FFF_FFFF;
                    else if (a1[31])          bmp_h = 32'd0 - a1;
                    else                      bmp_h = a1;
                    cr.found = 1'b1;
                    cv       = 1'b1;
                    if (m[ihds_pkg::SM_PNG] && sp == 5'd23) begin
                        cr.format = ihds_pkg::FMT_PNG;
                        cr.width  = a0;
                        cr.height = a1;
                    end else if (m[ihds_pkg::SM_GIF] && sp == 5'd9) begin
                        cr.format = ihds_pkg::FMT_GIF;
                        cr.width  = a0;
                        cr.height = a1;
                    end else if (m[ihds_pkg::SM_BMP] && sp == 5'd25) begin
                        cr.format = ihds_pkg::FMT_BMP;
                        cr.width  = a0;
                        cr.height = bmp_h;
                    end else if (m[ihds_pkg::SM_VP8] && sp == 5'd29) begin
                        cr.format = ihds_pkg::FMT_VP8;
                        cr.width  = a0 & ihds_pkg::MASK_14;
                        cr.height = a1 & ihds_pkg::MASK_14;
                    end else if (m[ihds_pkg::SM_VP8L] && sp == 5'd29) begin
                        cr.format = ihds_pkg::FMT_VP8L;
                        cr.width  = (a0 & ihds_pkg::MASK_14) + 32'd1;
                        cr.height = ((a0 >> 14) & ihds_pkg::MASK_14) + 32'd1;
                    end else if (m[ihds_pkg::SM_VP8X] && sp == 5'd29) begin
                        cr.format = ihds_pkg::FMT_VP8X;
                        cr.width  = (a0 & ihds_pkg::MASK_24) + 32'd1;
                        cr.height = (a1 & ihds_pkg::MASK_24) + 32'd1;
                    end else begin
                        cv = 1'b0;
                        cr = '0;
                    end
                    if (cv) begin
                        done_next  = 1'b1;
                        phase_next = ihds_pkg::PH_DONE;
                    end else if (sp >= 5'd29) begin
                        phase_next = ihds_pkg::PH_DONE;
                    end
                end
            end

            ihds_pkg::PH_SEEK: begin
                if (in_byte == 8'hFF) phase_next = ihds_pkg::PH_MARK;
            end

            ihds_pkg::PH_MARK: begin
                marker_next = in_byte;
                if (in_byte[7:4] == 4'hC && in_byte != 8'hC4 && in_byte != 8'hC8
                        && in_byte != 8'hCC) begin
                    skip_next  = 17'd2;
                    phase_next = ihds_pkg::PH_SOF;
                end else if (in_byte == 8'hD8 || in_byte == 8'hD9 || in_byte[7:3] == 5'b11010) begin
                    phase_next = ihds_pkg::PH_SEEK;
                end else begin
                    phase_next = ihds_pkg::PH_LEN1;
                end
            end

            ihds_pkg::PH_LEN1: begin
                seglen_next = {in_byte, 8'd0};
                phase_next  = ihds_pkg::PH_LEN2;
            end

            ihds_pkg::PH_LEN2: begin
                seglen_next = {seglen_reg[15:8], in_byte};
                q_next      = 16'd0;
                if (seglen_next < 16'd2) begin
                    phase_next = ihds_pkg::PH_DONE;
                end else begin
                    skip_next  = {1'b0, seglen_next - 16'd2};
                    exph_next  = (marker_reg == ihds_pkg::MARK_APP1 && orient_reg == 4'd0)
                                 ? ihds_pkg::EX_HEAD : ihds_pkg::EX_IDLE;
                    phase_next = (skip_next != 17'd0) ? ihds_pkg::PH_SKIP : ihds_pkg::PH_SEEK;
                end
            end

            ihds_pkg::PH_SKIP: begin
                // exif reader rides along the skipped segment
                if (exph_reg != ihds_pkg::EX_IDLE) begin
                    if (q_reg < 16'd6) begin
                        if (in_byte != exif_exp) exph_next = ihds_pkg::EX_IDLE;
                    end else if (rel < 16'd7) begin
                        // header bytes are stored below
                    end else if (rel == 16'd7) begin
                        le_next     = le_new;
                        ifdpos_next = ifd_new;
                        if (!tiff_ii && !tiff_mm) begin
                            exph_next = ihds_pkg::EX_IDLE;
                        end else if (magic != ihds_pkg::TIFF_MAGIC || range_bad) begin
                            exph_next = ihds_pkg::EX_IDLE;
                        end else begin
                            exph_next = ihds_pkg::EX_IFD;
                            // ifd that starts inside the tiff header
                            if (ifd_new < 32'd8) begin
                                entries_next = e0;
                                jcnt_next    = 4'(3'd6 - ifd_lo);
                                if (ifd_lo <= 3'd6) begin
                                    entries_next = e1;
                                    if (e1 == 16'd0) exph_next = ihds_pkg::EX_IDLE;
                                end
                                if (ifd_lo <= 3'd5 && e1 != 16'd0) begin
                                    tag_next = ihds_pkg::put16(le_new, 1'b0, 16'd0, hv2);
                                    if (ifd_lo <= 3'd4)
                                        tag_next = ihds_pkg::put16(le_new, 1'b1, tag_next, hv3);
                                end
                            end
                        end
                    end else if (exph_reg == ihds_pkg::EX_IFD) begin
                        if (k0) begin
                            entries_next = ihds_pkg::put16(le_reg, 1'b0, entries_reg, in_byte);
                        end else if (k1) begin
                            entries_next = ihds_pkg::put16(le_reg, 1'b1, entries_reg, in_byte);
                            jcnt_next    = 4'd0;
                            if (entries_next == 16'd0) exph_next = ihds_pkg::EX_IDLE;
                        end else if (kgt) begin
                            jcnt_next = (jcnt_reg == 4'd11) ? 4'd0 : jcnt_reg + 4'd1;
                            case (jcnt_reg)
                                4'd0: tag_next = ihds_pkg::put16(le_reg, 1'b0, tag_reg, in_byte);
                                4'd1: tag_next = ihds_pkg::put16(le_reg, 1'b1, tag_reg, in_byte);
                                4'd8: acc1_next = {16'd0, ihds_pkg::put16(le_reg, 1'b0,
                                                   acc1_reg[15:0], in_byte)};
                                4'd9: acc1_next = {16'd0, ihds_pkg::put16(le_reg, 1'b1,
                                                   acc1_reg[15:0], in_byte)};
                                4'd11: begin
                                    if (tag_reg == ihds_pkg::TAG_ORIENT) begin
                                        if (acc1_reg[15:0] >= 16'd1 && acc1_reg[15:0] <= 16'd8)
                                            orient_next = acc1_reg[3:0];
                                        exph_next = ihds_pkg::EX_IDLE;
                                    end else begin
                                        entries_next = entries_reg - 16'd1;
                                        if (entries_next == 16'd0) exph_next = ihds_pkg::EX_IDLE;
                                    end
                                end
                                default: ;
                            endcase
                        end
                    end
                end
                q_next    = q_reg + 16'd1;
                skip_next = skip_reg - 17'd1;
                if (skip_next == 17'd0) begin
                    exph_next  = ihds_pkg::EX_IDLE;
                    phase_next = ihds_pkg::PH_SEEK;
                end
            end

            ihds_pkg::PH_SOF: begin
                // sof: height then width, reported on the byte after them
                case (skip_reg[3:0])
                    4'd5: acc1_next = {16'd0, in_byte, 8'd0};
                    4'd6: acc1_next = acc1_reg | {24'd0, in_byte};
                    4'd7: acc0_next = {16'd0, in_byte, 8'd0};
                    4'd8: acc0_next = acc0_reg | {24'd0, in_byte};
                    4'd9: begin
                        cv         = 1'b1;
                        cr.found   = 1'b1;
                        cr.format  = ihds_pkg::FMT_JPEG;
                        cr.swapped = orient_reg >= 4'd5;
                        cr.width   = (orient_reg >= 4'd5) ? acc1_reg : acc0_reg;
                        cr.height  = (orient_reg >= 4'd5) ? acc0_reg : acc1_reg;
                        done_next  = 1'b1;
                        phase_next = ihds_pkg::PH_DONE;
                    end
                    default: ;
                endcase
                skip_next = skip_reg + 17'd1;
            end

            default: ;
        endcase

        // end of file: failure result if nothing found, then back to reset
        if (in_last) begin
            if (!done_next) begin
                cv = 1'b1;
                cr = '0;
            end
            pos_next     = '0;
            phase_next   = ihds_pkg::PH_SIG;
            exph_next    = ihds_pkg::EX_IDLE;
            match_next   = ihds_pkg::SM_ALL;
            acc0_next    = 32'd0;
            acc1_next    = 32'd0;
            skip_next    = 17'd0;
            seglen_next  = 16'd0;
            marker_next  = 8'd0;
            le_next      = 1'b0;
            ifdpos_next  = 32'd0;
            entries_next = 16'd0;
            tag_next     = 16'd0;
            orient_next  = 4'd0;
            done_next    = 1'b0;
            q_next       = 16'd0;
            jcnt_next    = 4'd0;
        end
    end

    assign res_valid = cv && acc;
    assign res       = cr;

    // parse state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= '0;
            phase_reg   <= ihds_pkg::PH_SIG;
            exph_reg    <= ihds_pkg::EX_IDLE;
            match_reg   <= ihds_pkg::SM_ALL;
            acc0_reg    <= 32'd0;
            acc1_reg    <= 32'd0;
            skip_reg    <= 17'd0;
            seglen_reg  <= 16'd0;
            marker_reg  <= 8'd0;
            le_reg      <= 1'b0;
            ifdpos_reg  <= 32'd0;
            entries_reg <= 16'd0;
            tag_reg     <= 16'd0;
            orient_reg  <= 4'd0;
            done_reg    <= 1'b0;
            q_reg       <= 16'd0;
            jcnt_reg    <= 4'd0;
        end else if (acc) begin
            pos_reg     <= pos_next;
            phase_reg   <= phase_next;
            exph_reg    <= exph_next;
            match_reg   <= match_next;
            acc0_reg    <= acc0_next;
            acc1_reg    <= acc1_next;
            skip_reg    <= skip_next;
            seglen_reg  <= seglen_next;
            marker_reg  <= marker_next;
            le_reg      <= le_next;
            ifdpos_reg  <= ifdpos_next;
            entries_reg <= entries_next;
            tag_reg     <= tag_next;
            orient_reg  <= orient_next;
            done_reg    <= done_next;
            q_reg       <= q_next;
            jcnt_reg    <= jcnt_next;
        end
    end

    // tiff header bytes, no reset
    always_ff @(posedge aclk) begin
        if (acc && phase_reg == ihds_pkg::PH_SKIP && exph_reg == ihds_pkg::EX_HEAD
                && q_reg >= 16'd6 && rel < 16'd7) begin
            hb_reg[rel[2:0]] <= in_byte;
        end
    end

    `IHDS_ASSERT(a_res_on_accept, res_valid |-> (in_valid && in_ready))
    `IHDS_NEVER(a_one_result, res_valid && done_reg)
    `IHDS_ASSERT(a_last_restarts, (acc && in_last) |=> (phase_reg == ihds_pkg::PH_SIG && pos_reg == '0))

endmodule

/* design/ihds_queue.sv */
// ----------------------------------------------------------------------------
// ihds_queue
// back part: two entry result queue whose head drives the result channel
// ----------------------------------------------------------------------------
`include "image_header_dimension_sniffer_top_assert.svh"

module ihds_queue (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   push,
    input  ihds_pkg::ihds_result_t push_data,
    output logic                   not_full,
    output logic                   out_valid,
    input  logic                   out_ready,
    output ihds_pkg::ihds_result_t out_data
);

    ihds_pkg::ihds_result_t mem_reg [2];
    logic       wr_reg, rd_reg;
    logic [1:0] count_reg, count_next;
    logic       pop;

    assign not_full  = count_reg != 2'd2;
    assign out_valid = count_reg != 2'd0;
    assign out_data  = mem_reg[rd_reg];
    assign pop       = out_valid && out_ready;

    // occupancy
    always_comb begin
        count_next = count_reg;
        if (push && !pop)      count_next = count_reg + 2'd1;
        else if (!push && pop) count_next = count_reg - 2'd1;
    end

    // pointers and count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg    <= 1'b0;
            rd_reg    <= 1'b0;
            count_reg <= 2'd0;
        end else begin
            if (push) wr_reg <= ~wr_reg;
            if (pop)  rd_reg <= ~rd_reg;
            count_reg <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (push) mem_reg[wr_reg] <= push_data;
    end

    `IHDS_NEVER(a_count_range, count_reg == 2'd3)
    `IHDS_NEVER(a_no_push_full, push && !not_full)
    `IHDS_ASSERT(a_pop_drains, (pop && !push) |=> (count_reg == $past(count_reg) - 2'd1))

endmodule

/* design/image_header_dimension_sniffer_top.sv */
// ----------------------------------------------------------------------------
// image_header_dimension_sniffer_top
// Input channel s_*: one file byte per transaction, s_tlast on the final byte.
// Result channel m_*: one transaction per file, found=0 when no image size
// was recognized (png, gif, bmp, webp vp8/vp8l/vp8x, jpeg with exif
// orientation swap).
// Throughput: one byte per cycle while s_tready is high; the parser
// updates all its state in the cycle a byte is accepted.
// The result is pushed into the queue as the deciding byte (or the last
// byte on failure) is accepted and reaches m_tvalid from the queue head.
// A two entry result queue sits between parser and output, so the parser
// keeps taking bytes while a result waits; s_tready drops only when both
// entries are held by a stalled receiver.
// Reset (aresetn low, synchronous) clears the parser and empties the queue;
// the last byte of each file also returns the parser to its reset state.
// ----------------------------------------------------------------------------
module image_header_dimension_sniffer_top #(
    parameter int POSITION_BITS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata    // [0] found, [3:1] format, [35:4] width,
                                   // [67:36] height, [68] swapped, rest zero
);

    logic                   res_valid;
    ihds_pkg::ihds_result_t res;
    ihds_pkg::ihds_result_t head;
    logic                   q_not_full;

    assign s_tready = q_not_full;

    // byte parser
    ihds_parse #(
        .POSITION_BITS(POSITION_BITS)
    ) u_parse (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (q_not_full),
        .in_byte  (s_tdata),
        .in_last  (s_tlast),
        .res_valid(res_valid),
        .res      (res)
    );

    // result queue
    ihds_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (res_valid),
        .push_data(res),
        .not_full (q_not_full),
        .out_valid(m_tvalid),
        .out_ready(m_tready),
        .out_data (head)
    );

    // result packing
    assign m_tdata = {3'd0, head.swapped, head.height, head.width, head.format, head.found};

endmodule

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the image header dimension sniffer. Whole files
// (png, gif, bmp, webp, jpeg with and without exif, noise, truncated and
// corrupted files) are streamed byte by byte with random gaps on both sides.
// A built-in size parser predicts the one result of every file, and each
// result transaction is compared field by field in arrival order.
// ----------------------------------------------------------------------------
module tb_top;

    // jpeg marker codes
    localparam logic [7:0] MK_PREFIX = 8'hFF;
    localparam logic [7:0] MK_SOF_LO = 8'hC0;
    localparam logic [7:0] MK_SOF_HI = 8'hCF;
    localparam logic [7:0] MK_DHT    = 8'hC4;
    localparam logic [7:0] MK_JPG    = 8'hC8;
    localparam logic [7:0] MK_DAC    = 8'hCC;
    localparam logic [7:0] MK_RST0   = 8'hD0;
    localparam logic [7:0] MK_RST7   = 8'hD7;
    localparam logic [7:0] MK_SOI    = 8'hD8;
    localparam logic [7:0] MK_EOI    = 8'hD9;
    localparam logic [7:0] MK_APP0   = 8'hE0;
    localparam logic [7:0] MK_COM    = 8'hFE;

    localparam logic [7:0] PNG_MAGIC [8] = '{8'h89, 8'h50, 8'h4E, 8'h47,
                                            8'h0D, 8'h0A, 8'h1A, 8'h0A};
    localparam logic [7:0] GIF_MAGIC [6] = '{8'h47, 8'h49, 8'h46, 8'h38, 8'h37, 8'h61};
    localparam logic [7:0] GIF_VER9      = 8'h39;
    localparam logic [7:0] RIFF_MAGIC [4] = '{8'h52, 8'h49, 8'h46, 8'h46};
    localparam logic [7:0] VP8_STEM [3]  = '{8'h56, 8'h50, 8'h38};
    localparam logic [7:0] CC_VP8        = 8'h20;
    localparam logic [7:0] CC_VP8L       = 8'h4C;
    localparam logic [7:0] CC_VP8X       = 8'h58;
    localparam logic [7:0] EXIF_MAGIC [6] = '{8'h45, 8'h78, 8'h69, 8'h66, 8'h00, 8'h00};
    localparam logic [7:0] CH_B = 8'h42;
    localparam logic [7:0] CH_M = 8'h4D;
    localparam logic [7:0] CH_I = 8'h49;

    // jpeg builder options
    localparam int JQ_FFFF    = 1;
    localparam int JQ_STAND   = 2;
    localparam int JQ_EMPTY   = 4;
    localparam int JQ_BADLEN  = 8;
    localparam int JQ_EXIF    = 16;
    localparam int JQ_MOTO    = 32;
    localparam int JQ_LOWOFF  = 64;
    localparam int JQ_TAGLATE = 128;
    localparam int JQ_OVERRUN = 256;
    localparam int JQ_JUNKAPP = 512;
    localparam int JQ_APP0    = 1024;

    localparam int HOLD_CYCLES = 400;

    typedef enum int {K_PNG, K_GIF, K_BMP, K_VP8, K_VP8L, K_VP8X, K_JPEG, K_NOISE} img_kind_t;

    typedef struct {
        img_kind_t              kind;
        logic [31:0]            w;
        logic [31:0]            h;
        int                     q;
        int                     o;
        bit                     typed;
        ihds_pkg::ihds_result_t res;
    } plan_row_t;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        s_tlast = 0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [71:0] m_tdata;

    image_header_dimension_sniffer_top DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always #1 aclk = ~aclk;

    // failure timer
    initial begin
        #2000000;
        $display("[FAIL] regression broken");
        $finish;
    end

    int errors = 0;

    task automatic report(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        errors++;
    endtask

    // ---------------- size parser state ----------------
    logic [31:0]           pos;
    ihds_pkg::ihds_phase_t ph;
    logic [6:0]            cand;
    logic [31:0]           acc0, acc1;
    logic [31:0]           skip;
    logic [15:0]           seglen;
    logic [7:0]            marker;
    bit                    le;
    logic [7:0]            hdr [8];
    logic [31:0]           ifdpos;
    logic [15:0]           entries, tag;
    logic [3:0]            orient;
    bit                    done;
    ihds_pkg::ihds_exif_t  exph;

    function automatic ihds_pkg::ihds_result_t mk_res(input bit found, input logic [2:0] fmt,
                                                      input logic [31:0] w,
                                                      input logic [31:0] h,
                                                      input bit sw);
        ihds_pkg::ihds_result_t r;
        r.found = found; r.format = fmt; r.width = w; r.height = h; r.swapped = sw;
        return r;
    endfunction

    task automatic parser_clear();
        pos = 0; ph = ihds_pkg::PH_SIG; cand = ihds_pkg::SM_ALL; acc0 = 0; acc1 = 0;
        skip = 0; seglen = 0; marker = 0; le = 0; ifdpos = 0; entries = 0; tag = 0;
        orient = 0; done = 0; exph = ihds_pkg::EX_IDLE;
        foreach (hdr[i]) hdr[i] = 0;
    endtask

    function automatic logic [15:0] join16(input logic [15:0] cur, input int idx,
                                           input logic [7:0] b);
        int sh;
        sh = le ? 8 * idx : 8 * (1 - idx);
        if (idx == 0) cur = 0;
        return cur | (16'(b) << sh);
    endfunction

    function automatic logic [15:0] hdr16(input int i);
        return le ? {hdr[i+1], hdr[i]} : {hdr[i], hdr[i+1]};
    endfunction

    function automatic logic [31:0] hdr32(input int i);
        return le ? {hdr16(i + 2), hdr16(i)} : {hdr16(i), hdr16(i + 2)};
    endfunction

    // one byte of the ifd0 entry table
    task automatic ifd_take(input logic [31:0] rel, input logic [7:0] b);
        logic [31:0] k, j;
        if (exph != ihds_pkg::EX_IFD || rel < ifdpos) return;
        k = rel - ifdpos;
        if (k < 2) begin
            entries = join16(entries, k, b);
            if (k == 1 && entries == 0) exph = ihds_pkg::EX_IDLE;
            return;
        end
        j = (k - 2) % 12;
        if (j < 2) tag = join16(tag, j, b);
        else if (j == 8 || j == 9) acc1 = {16'd0, join16(acc1[15:0], j - 8, b)};
        else if (j == 11) begin
            if (tag == ihds_pkg::TAG_ORIENT) begin
                if (acc1[15:0] >= 1 && acc1[15:0] <= 8) orient = acc1[3:0];
                exph = ihds_pkg::EX_IDLE;
            end else begin
                entries--;
                if (entries == 0) exph = ihds_pkg::EX_IDLE;
            end
        end
    endtask

    // one byte of an app1 payload
    task automatic exif_take(input logic [31:0] q, input logic [7:0] b);
        logic [31:0] rel, r;
        if (exph == ihds_pkg::EX_IDLE) return;
        if (q < 6) begin
            if (b != EXIF_MAGIC[q]) exph = ihds_pkg::EX_IDLE;
            return;
        end
        rel = q - 6;
        if (rel >= 8) begin
            ifd_take(rel, b);
            return;
        end
        hdr[rel] = b;
        if (rel != 7) return;
        if (hdr[0] == CH_I && hdr[1] == CH_I) le = 1;
        else if (hdr[0] == CH_M && hdr[1] == CH_M) le = 0;
        else begin
            exph = ihds_pkg::EX_IDLE;
            return;
        end
        if (hdr16(2) != ihds_pkg::TIFF_MAGIC) begin
            exph = ihds_pkg::EX_IDLE;
            return;
        end
        ifdpos = hdr32(4);
        if (longint'(ifdpos) + 2 > longint'(seglen) - 8) begin
            exph = ihds_pkg::EX_IDLE;
            return;
        end
        exph = ihds_pkg::EX_IFD;
        // ifd starting inside the tiff header
        for (r = ifdpos; r < 8 && exph == ihds_pkg::EX_IFD; r++) ifd_take(r, hdr[r]);
    endtask

    // signature phase, fixed byte positions
    task automatic sig_take(input int p, input logic [7:0] b,
                            output bit got, output ihds_pkg::ihds_result_t res);
        logic [6:0]  m;
        logic [31:0] a0, a1, hh;
        got = 0;
        m = cand; a0 = acc0; a1 = acc1;
        if (p < 8 && b != PNG_MAGIC[p]) m[ihds_pkg::SM_PNG] = 0;
        if (p < 6 && !(b == GIF_MAGIC[p] || (p == 4 && b == GIF_VER9)))
            m[ihds_pkg::SM_GIF] = 0;
        if (p == 0 && b != CH_B) m[ihds_pkg::SM_BMP] = 0;
        if (p == 1 && b != CH_M) m[ihds_pkg::SM_BMP] = 0;
        if (p < 4 && b != RIFF_MAGIC[p]) begin
            m[ihds_pkg::SM_VP8] = 0; m[ihds_pkg::SM_VP8L] = 0; m[ihds_pkg::SM_VP8X] = 0;
        end
        if (p >= 12 && p < 15 && b != VP8_STEM[p-12]) begin
            m[ihds_pkg::SM_VP8] = 0; m[ihds_pkg::SM_VP8L] = 0; m[ihds_pkg::SM_VP8X] = 0;
        end
        if (p == 15) begin
            if (b != CC_VP8)  m[ihds_pkg::SM_VP8] = 0;
            if (b != CC_VP8L) m[ihds_pkg::SM_VP8L] = 0;
            if (b != CC_VP8X) m[ihds_pkg::SM_VP8X] = 0;
        end
        if (p == 0 && b != MK_PREFIX) m[ihds_pkg::SM_JPEG] = 0;
        if (p == 1 && b != MK_SOI) m[ihds_pkg::SM_JPEG] = 0;
        cand = m;
        if (m == 0) begin
            ph = ihds_pkg::PH_DONE;
            return;
        end
        if (p == 1 && m[ihds_pkg::SM_JPEG]) begin
            ph = ihds_pkg::PH_SEEK;
            return;
        end
        if (m[ihds_pkg::SM_PNG] && p >= 16 && p < 24) begin
            if (p < 20) a0 |= 32'(b) << (8 * (3 - (p - 16) % 4));
            else a1 |= 32'(b) << (8 * (3 - (p - 16) % 4));
        end
        if (m[ihds_pkg::SM_GIF] && p >= 6 && p < 10) begin
            if (p < 8) a0 |= 32'(b) << (8 * (p - 6)); else a1 |= 32'(b) << (8 * (p - 8));
        end
        if (m[ihds_pkg::SM_BMP] && p >= 18 && p < 26) begin
            if (p < 22) a0 |= 32'(b) << (8 * ((p - 18) % 4));
            else a1 |= 32'(b) << (8 * ((p - 18) % 4));
        end
        if (m[ihds_pkg::SM_VP8] && p >= 26 && p < 30) begin
            if (p < 28) a0 |= 32'(b) << (8 * (p - 26)); else a1 |= 32'(b) << (8 * (p - 28));
        end
        if (m[ihds_pkg::SM_VP8L] && p >= 21 && p < 25) a0 |= 32'(b) << (8 * (p - 21));
        if (m[ihds_pkg::SM_VP8X] && p >= 24 && p < 30) begin
            if (p < 27) a0 |= 32'(b) << (8 * (p - 24)); else a1 |= 32'(b) << (8 * (p - 27));
        end
        acc0 = a0; acc1 = a1;
        got = 1;
        if (m[ihds_pkg::SM_PNG] && p == 23) res = mk_res(1, ihds_pkg::FMT_PNG, a0, a1, 0);
        else if (m[ihds_pkg::SM_GIF] && p == 9) res = mk_res(1, ihds_pkg::FMT_GIF, a0, a1, 0);
        else if (m[ihds_pkg::SM_BMP] && p == 25) begin
            // absolute height, most negative saturates
            if (a1 == 32'h8000_0000) hh = 32'h7FFF_FFFF;
            else if (a1[31]) hh = -a1;
            else hh = a1;
            res = mk_res(1, ihds_pkg::FMT_BMP, a0, hh, 0);
        end else if (m[ihds_pkg::SM_VP8] && p == 29)
            res = mk_res(1, ihds_pkg::FMT_VP8, a0 & ihds_pkg::MASK_14,
                         a1 & ihds_pkg::MASK_14, 0);
        else if (m[ihds_pkg::SM_VP8L] && p == 29)
            res = mk_res(1, ihds_pkg::FMT_VP8L, (a0 & ihds_pkg::MASK_14) + 1,
                         ((a0 >> 14) & ihds_pkg::MASK_14) + 1, 0);
        else if (m[ihds_pkg::SM_VP8X] && p == 29)
            res = mk_res(1, ihds_pkg::FMT_VP8X, (a0 & ihds_pkg::MASK_24) + 1,
                         (a1 & ihds_pkg::MASK_24) + 1, 0);
        else begin
            got = 0;
            if (p >= 29) ph = ihds_pkg::PH_DONE;
            return;
        end
        done = 1;
        ph = ihds_pkg::PH_DONE;
    endtask

    // jpeg marker walk
    task automatic jpeg_take(input logic [7:0] b, output bit got,
                             output ihds_pkg::ihds_result_t res);
        logic [31:0] i;
        got = 0;
        case (ph)
            ihds_pkg::PH_SEEK: if (b == MK_PREFIX) ph = ihds_pkg::PH_MARK;
            ihds_pkg::PH_MARK: begin
                marker = b;
                if (b >= MK_SOF_LO && b <= MK_SOF_HI && b != MK_DHT && b != MK_JPG
                    && b != MK_DAC) begin
                    skip = 2;
                    ph = ihds_pkg::PH_SOF;
                end else if (b == MK_SOI || b == MK_EOI || (b >= MK_RST0 && b <= MK_RST7))
                    ph = ihds_pkg::PH_SEEK;
                else
                    ph = ihds_pkg::PH_LEN1;
            end
            ihds_pkg::PH_LEN1: begin
                seglen = {b, 8'd0};
                ph = ihds_pkg::PH_LEN2;
            end
            ihds_pkg::PH_LEN2: begin
                seglen = seglen | b;
                if (seglen < 2) ph = ihds_pkg::PH_DONE;
                else begin
                    skip = seglen - 2;
                    exph = (marker == ihds_pkg::MARK_APP1 && orient == 0)
                           ? ihds_pkg::EX_HEAD : ihds_pkg::EX_IDLE;
                    ph = (skip != 0) ? ihds_pkg::PH_SKIP : ihds_pkg::PH_SEEK;
                end
            end
            ihds_pkg::PH_SKIP: begin
                exif_take((32'(seglen) - 2) - skip, b);
                skip--;
                if (skip == 0) begin
                    exph = ihds_pkg::EX_IDLE;
                    ph = ihds_pkg::PH_SEEK;
                end
            end
            ihds_pkg::PH_SOF: begin
                i = skip;
                if (i == 5) acc1 = 32'(b) << 8;
                else if (i == 6) acc1 |= b;
                else if (i == 7) acc0 = 32'(b) << 8;
                else if (i == 8) acc0 |= b;
                else if (i == 9) begin
                    if (orient >= 5) res = mk_res(1, ihds_pkg::FMT_JPEG, acc1, acc0, 1);
                    else res = mk_res(1, ihds_pkg::FMT_JPEG, acc0, acc1, 0);
                    got = 1;
                    done = 1;
                    ph = ihds_pkg::PH_DONE;
                end
                skip = i + 1;
            end
            default: ;
        endcase
    endtask

    task automatic sniff_byte(input logic [7:0] b, input bit last,
                              output bit got, output ihds_pkg::ihds_result_t res);
        got = 0;
        if (ph == ihds_pkg::PH_SIG) sig_take(pos < 64 ? int'(pos) : 64, b, got, res);
        else if (ph != ihds_pkg::PH_DONE) jpeg_take(b, got, res);
        if (pos != '1) pos++;
        if (last) begin
            if (!done) begin
                res = mk_res(0, ihds_pkg::FMT_PNG, 0, 0, 0);
                got = 1;
            end
            parser_clear();
        end
    endtask

    // ---------------- checking ----------------
    ihds_pkg::ihds_result_t pending_sizes[$];
    bit                     typed_on [int];
    ihds_pkg::ihds_result_t typed_val [int];
    int                     files_seen = 0;

    always @(posedge aclk) begin
        ihds_pkg::ihds_result_t got_r, want;
        bit got;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got_r = m_tdata[68:0];
                if (pending_sizes.size() == 0) report("result with nothing expected");
                else begin
                    want = pending_sizes.pop_front();
                    if (got_r.found !== want.found)
                        report($sformatf("found %0b want %0b", got_r.found, want.found));
                    if (got_r.format !== want.format)
                        report($sformatf("format %0d want %0d", got_r.format, want.format));
                    if (got_r.width !== want.width)
                        report($sformatf("width %h want %h", got_r.width, want.width));
                    if (got_r.height !== want.height)
                        report($sformatf("height %h want %h", got_r.height, want.height));
                    if (got_r.swapped !== want.swapped)
                        report($sformatf("swapped %0b want %0b", got_r.swapped, want.swapped));
                    if (m_tdata[71:69] !== 3'b000) report("padding bits not zero");
                end
            end
            if (s_tvalid && s_tready) begin
                sniff_byte(s_tdata, s_tlast, got, want);
                if (got) begin
                    if (typed_on.exists(files_seen)) want = typed_val[files_seen];
                    pending_sizes.push_back(want);
                end
                if (s_tlast) files_seen++;
            end
        end
    end

    // ---------------- receiver ----------------
    int hold_asked = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int stall_left = 0;

    always @(negedge aclk) begin
        int r;
        if (hold_asked != hold_seen) begin
            hold_seen = hold_asked;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_tready <= 0;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 3) stall_left = $urandom_range(10, 40);
            else if (r < 25) stall_left = $urandom_range(0, 2);
            m_tready <= (r >= 25);
        end
    end

    // ---------------- file builder ----------------
    logic [7:0] img[$];
    int bytes_sent = 0;
    int files_sent = 0;

    task automatic put_n(ref logic [7:0] dst[$], input logic [31:0] v, input int n,
                         input bit little);
        for (int i = 0; i < n; i++)
            dst.push_back(little ? v[8*i +: 8] : v[8*(n-1-i) +: 8]);
    endtask

    task automatic put_rand(ref logic [7:0] dst[$], input int n);
        repeat (n) dst.push_back($urandom_range(0, 255));
    endtask

    task automatic put_exif(input int q, input int o);
        logic [7:0] pl[$];
        bit lit;
        int cnt;
        lit = !(q & JQ_MOTO);
        foreach (EXIF_MAGIC[i]) pl.push_back(EXIF_MAGIC[i]);
        pl.push_back(lit ? CH_I : CH_M);
        pl.push_back(lit ? CH_I : CH_M);
        put_n(pl, ihds_pkg::TIFF_MAGIC, 2, lit);
        put_n(pl, (q & JQ_LOWOFF) ? $urandom_range(0, 7) : 8, 4, lit);
        cnt = (q & JQ_TAGLATE) ? 2 : 1;
        put_n(pl, (q & JQ_OVERRUN) ? 40 : cnt, 2, lit);
        if (q & JQ_TAGLATE) begin
            put_n(pl, $urandom_range(0, 16'hFFFF), 2, lit);
            put_rand(pl, 10);
        end
        put_n(pl, ihds_pkg::TAG_ORIENT, 2, lit);
        put_n(pl, 3, 2, lit);
        put_n(pl, 1, 4, lit);
        put_n(pl, o, 2, lit);
        put_n(pl, 0, 2, lit);
        put_n(pl, 0, 4, lit);
        img.push_back(MK_PREFIX);
        img.push_back(ihds_pkg::MARK_APP1);
        put_n(img, pl.size() + 2, 2, 0);
        foreach (pl[i]) img.push_back(pl[i]);
    endtask

    task automatic build_file(input img_kind_t kind, input logic [31:0] w,
                              input logic [31:0] h, input int q, input int o);
        logic [7:0] sof;
        img.delete();
        if (kind inside {K_VP8, K_VP8L, K_VP8X}) begin
            foreach (RIFF_MAGIC[i]) img.push_back(RIFF_MAGIC[i]);
            put_rand(img, 8);
            foreach (VP8_STEM[i]) img.push_back(VP8_STEM[i]);
        end
        case (kind)
            K_PNG: begin
                foreach (PNG_MAGIC[i]) img.push_back(PNG_MAGIC[i]);
                put_rand(img, 8);
                put_n(img, w, 4, 0);
                put_n(img, h, 4, 0);
                put_rand(img, 5);
            end
            K_GIF: begin
                foreach (GIF_MAGIC[i]) img.push_back(GIF_MAGIC[i]);
                if (q & 1) img[4] = GIF_VER9;
                put_n(img, w, 2, 1);
                put_n(img, h, 2, 1);
                put_rand(img, 3);
            end
            K_BMP: begin
                img.push_back(CH_B);
                img.push_back(CH_M);
                put_rand(img, 16);
                put_n(img, w, 4, 1);
                put_n(img, h, 4, 1);
                put_rand(img, 2);
            end
            K_VP8: begin
                img.push_back(CC_VP8);
                put_rand(img, 10);
                put_n(img, w, 2, 1);
                put_n(img, h, 2, 1);
                put_rand(img, 2);
            end
            K_VP8L: begin
                img.push_back(CC_VP8L);
                put_rand(img, 5);
                put_n(img, w, 4, 1);
                put_rand(img, 6);
            end
            K_VP8X: begin
                img.push_back(CC_VP8X);
                put_rand(img, 8);
                put_n(img, w, 3, 1);
                put_n(img, h, 3, 1);
                put_rand(img, 2);
            end
            K_JPEG: begin
                img.push_back(MK_PREFIX);
                img.push_back(MK_SOI);
                if (q & JQ_STAND) begin
                    img.push_back($urandom_range(0, 254));
                    put_n(img, {MK_PREFIX, MK_RST0 + 8'($urandom_range(0, 7))}, 2, 0);
                    put_n(img, {MK_PREFIX, MK_SOI, MK_PREFIX, MK_EOI}, 4, 0);
                end
                if (q & JQ_FFFF) put_n(img, {MK_PREFIX, MK_PREFIX, 16'd4}, 4, 0);
                if (q & JQ_FFFF) put_rand(img, 2);
                if (q & JQ_EMPTY) put_n(img, {MK_PREFIX, MK_COM, 16'd2}, 4, 0);
                if (q & JQ_APP0) begin
                    put_n(img, {MK_PREFIX, MK_APP0, 16'd7}, 4, 0);
                    put_rand(img, 5);
                end
                if (q & JQ_BADLEN) put_n(img, {MK_PREFIX, MK_APP0, 15'd0, q[0]}, 4, 0);
                if (q & JQ_JUNKAPP) begin
                    put_n(img, {MK_PREFIX, ihds_pkg::MARK_APP1, 16'd8}, 4, 0);
                    put_rand(img, 6);
                end
                if (q & JQ_EXIF) put_exif(q, o);
                do sof = $urandom_range(MK_SOF_LO, MK_SOF_HI);
                while (sof == MK_DHT || sof == MK_JPG || sof == MK_DAC);
                put_n(img, {MK_PREFIX, sof}, 2, 0);
                put_n(img, {16'd17, 8'd8}, 3, 0);
                put_n(img, h, 2, 0);
                put_n(img, w, 2, 0);
                put_rand(img, 3);
            end
            default: put_rand(img, h);
        endcase
    endtask

    // ---------------- sender ----------------
    task automatic send_file(input bit typed, input ihds_pkg::ihds_result_t tr);
        int g;
        bit steady;
        if (typed) begin
            typed_on[files_sent] = 1;
            typed_val[files_sent] = tr;
        end
        steady = ($urandom_range(0, 3) == 0);
        foreach (img[i]) begin
            @(negedge aclk);
            s_tvalid <= 1;
            s_tdata <= img[i];
            s_tlast <= (i == img.size() - 1);
            @(posedge aclk);
            while (!s_tready) @(posedge aclk);
            bytes_sent++;
            g = $urandom_range(0, 99);
            g = steady ? 0 : (g < 65 ? 0 : g < 96 ? $urandom_range(1, 3) : $urandom_range(8, 40));
            if (g > 0) begin
                @(negedge aclk);
                s_tvalid <= 0;
                repeat (g - 1) @(negedge aclk);
            end
        end
        files_sent++;
    endtask

    task automatic drain_wait();
        @(negedge aclk);
        s_tvalid <= 0;
        while (pending_sizes.size() != 0) @(posedge aclk);
    endtask

    function automatic plan_row_t row(input img_kind_t k, input logic [31:0] w,
                                      input logic [31:0] h, input int q, input int o,
                                      input bit typed, input ihds_pkg::ihds_result_t res);
        plan_row_t r;
        r.kind = k; r.w = w; r.h = h; r.q = q; r.o = o; r.typed = typed; r.res = res;
        return r;
    endfunction

    initial begin
        plan_row_t plan[$];
        ihds_pkg::ihds_result_t none;
        img_kind_t k;
        int r, n;
        none = mk_res(0, ihds_pkg::FMT_PNG, 0, 0, 0);
        parser_clear();
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1;

        // directed files
        plan.push_back(row(K_PNG, '1, 0, 0, 0, 1, mk_res(1, ihds_pkg::FMT_PNG, '1, 0, 0)));
        plan.push_back(row(K_PNG, 0, '1, 0, 0, 1, mk_res(1, ihds_pkg::FMT_PNG, 0, '1, 0)));
        plan.push_back(row(K_GIF, 16'hFFFF, 0, 0, 0, 1,
                           mk_res(1, ihds_pkg::FMT_GIF, 16'hFFFF, 0, 0)));
        plan.push_back(row(K_GIF, 0, 16'hFFFF, 1, 0, 1,
                           mk_res(1, ihds_pkg::FMT_GIF, 0, 16'hFFFF, 0)));
        plan.push_back(row(K_BMP, '1, 32'h8000_0000, 0, 0, 1,
                           mk_res(1, ihds_pkg::FMT_BMP, '1, 32'h7FFF_FFFF, 0)));
        plan.push_back(row(K_BMP, 0, -32'sd5, 0, 0, 1, mk_res(1, ihds_pkg::FMT_BMP, 0, 5, 0)));
        plan.push_back(row(K_BMP, 1, 32'h7FFF_FFFF, 0, 0, 1,
                           mk_res(1, ihds_pkg::FMT_BMP, 1, 32'h7FFF_FFFF, 0)));
        plan.push_back(row(K_VP8, 16'hFFFF, 16'hFFFF, 0, 0, 1,
                           mk_res(1, ihds_pkg::FMT_VP8, 32'h3FFF, 32'h3FFF, 0)));
        plan.push_back(row(K_VP8L, '1, 0, 0, 0, 1,
                           mk_res(1, ihds_pkg::FMT_VP8L, 32'h4000, 32'h4000, 0)));
        plan.push_back(row(K_VP8L, 0, 0, 0, 0, 1, mk_res(1, ihds_pkg::FMT_VP8L, 1, 1, 0)));
        plan.push_back(row(K_VP8X, 24'hFFFFFF, 24'hFFFFFF, 0, 0, 1,
                           mk_res(1, ihds_pkg::FMT_VP8X, 32'h100_0000, 32'h100_0000, 0)));
        plan.push_back(row(K_JPEG, 16'hFFFF, 0, 0, 0, 1,
                           mk_res(1, ihds_pkg::FMT_JPEG, 16'hFFFF, 0, 0)));
        plan.push_back(row(K_JPEG, 7, 9, JQ_BADLEN, 0, 1, none));
        plan.push_back(row(K_JPEG, 7, 9, JQ_BADLEN | 1, 0, 1, none));
        plan.push_back(row(K_NOISE, 0, 1, 0, 0, 1, none));
        plan.push_back(row(K_JPEG, 10, 20, JQ_EXIF, 6, 1,
                           mk_res(1, ihds_pkg::FMT_JPEG, 20, 10, 1)));
        plan.push_back(row(K_JPEG, 33, 44, JQ_FFFF | JQ_STAND | JQ_EMPTY | JQ_APP0, 0, 0, none));
        plan.push_back(row(K_JPEG, 640, 480, JQ_EXIF | JQ_MOTO, 8, 0, none));
        plan.push_back(row(K_JPEG, 640, 480, JQ_EXIF | JQ_LOWOFF, 7, 0, none));
        plan.push_back(row(K_JPEG, 640, 480, JQ_EXIF | JQ_TAGLATE | JQ_MOTO, 3, 0, none));
        plan.push_back(row(K_JPEG, 640, 480, JQ_EXIF | JQ_OVERRUN, 7, 0, none));
        plan.push_back(row(K_JPEG, 640, 480, JQ_EXIF | JQ_JUNKAPP, 5, 0, none));
        plan.push_back(row(K_JPEG, 640, 480, JQ_EXIF, 9, 0, none));
        plan.push_back(row(K_NOISE, 0, 37, 0, 0, 0, none));

        foreach (plan[i]) begin
            build_file(plan[i].kind, plan[i].w, plan[i].h, plan[i].q, plan[i].o);
            if (i == 4) drain_wait();
            if (i == 8) hold_asked++;
            send_file(plan[i].typed, plan[i].res);
        end

        // random files, mostly well formed with random content
        while (bytes_sent < 2000 || files_sent < 90) begin
            k = img_kind_t'($urandom_range(0, 7));
            r = $urandom_range(0, 2);
            build_file(k, r == 0 ? $urandom : $urandom_range(0, 4000),
                       k == K_NOISE ? $urandom_range(1, 40) :
                       (r == 0 ? $urandom : $urandom_range(0, 4000)),
                       $urandom, $urandom_range(0, 9));
            r = $urandom_range(0, 99);
            if (r < 15) img[$urandom_range(0, img.size() - 1)] = $urandom_range(0, 255);
            else if (r < 30) begin
                n = $urandom_range(1, img.size());
                while (img.size() > n) void'(img.pop_back());
            end else put_rand(img, $urandom_range(0, 6));
            if (files_sent == 50) drain_wait();
            if (files_sent == 70) hold_asked++;
            send_file(0, none);
        end
        @(negedge aclk);
        s_tvalid <= 0;
        s_tlast <= 0;

        drain_wait();
        repeat (10) @(posedge aclk);
        if (errors == 0) $display("[ OK ] regression clean");
        else $display("[FAIL] regression broken");
        $finish;
    end
endmodule
